[hw/rtl/rbst_pkg.sv]
// Shared constants and register codes for the ray box slab test.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rbst_pkg;

    localparam int DIR_W     = 32;   // Q2.30 direction components
    localparam int DIR_FRAC  = 30;
    localparam int SCALE_W   = 32;   // margin scale, fraction of 2^-32
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DIR_W-1:0] DIR_X_RESET        = 32'sh4000_0000;
    localparam logic [SCALE_W-1:0]      MARGIN_SCALE_RESET = 32'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_ORIGIN_Z     = 3'd2,
        REG_DIR_X        = 3'd3,
        REG_DIR_Y        = 3'd4,
        REG_DIR_Z        = 3'd5,
        REG_MARGIN_SCALE = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

[hw/rtl/rbst_margin.sv]
// Safety margin pipeline: scale times the largest of 1.0, |origin| and the limit.
// Four register stages; uses rbst_pkg.
`default_nettype none

module rbst_margin #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [COORD_WIDTH-1:0]          origin_x,
    input  wire logic signed [COORD_WIDTH-1:0]          origin_y,
    input  wire logic signed [COORD_WIDTH-1:0]          origin_z,
    input  wire logic [rbst_pkg::SCALE_W-1:0]           margin_scale,
    input  wire logic [COORD_WIDTH-2:0]                 limit_in,
    output logic [COORD_WIDTH-1:0]                      margin,
    output logic [COORD_WIDTH-2:0]                      limit_out
);
    import rbst_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int MH_W = (CW > 16) ? CW - 16 : 1;
    localparam int PH_W = SCALE_W + MH_W;
    localparam int PL_W = SCALE_W + 16;
    localparam int SUM_W = PH_W + 1;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic [CW-1:0]    abs_reg [3];
    logic [CW-1:0]    mag_reg;
    logic [PH_W-1:0]  p_hi_reg;
    logic [PL_W-1:0]  p_lo_reg;
    logic [CW-1:0]    margin_reg;
    logic [CW-2:0]    lim_reg [4];

    logic [CW-1:0] org_u [3];
    logic [CW-1:0] abs_next [3];
    logic [CW-1:0] lim_w, m01, m23, mag_next;
    logic [MH_W-1:0] mh;
    logic [15:0]     ml;
    logic [SUM_W-1:0] sum_w;

    always_comb begin
        org_u[0] = origin_x;
        org_u[1] = origin_y;
        org_u[2] = origin_z;
        for (int k = 0; k < 3; k++) begin
            abs_next[k] = org_u[k][CW-1] ? (~org_u[k] + 1'b1) : org_u[k];
        end
        lim_w    = {1'b0, lim_reg[0]};
        m01      = (abs_reg[0] > ONE) ? abs_reg[0] : ONE;
        m23      = (abs_reg[1] > abs_reg[2]) ? abs_reg[1] : abs_reg[2];
        m01      = (lim_w > m01) ? lim_w : m01;
        mag_next = (m23 > m01) ? m23 : m01;
        mh       = MH_W'(mag_reg >> 16);
        ml       = mag_reg[15:0];
        sum_w    = SUM_W'(p_hi_reg) + SUM_W'(p_lo_reg >> 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg    <= abs_next;
            lim_reg[0] <= limit_in;
            mag_reg    <= mag_next;
            lim_reg[1] <= lim_reg[0];
            p_hi_reg   <= PH_W'(margin_scale) * PH_W'(mh);
            p_lo_reg   <= PL_W'(margin_scale) * PL_W'(ml);
            lim_reg[2] <= lim_reg[1];
            // margin stays below the magnitude, so it fits the coordinate width
            margin_reg <= CW'(sum_w >> 16);
            lim_reg[3] <= lim_reg[2];
        end
    end

    assign margin    = margin_reg;
    assign limit_out = lim_reg[3];

endmodule

`default_nettype wire

[hw/rtl/rbst_div.sv]
// Pipelined restoring divider for one slab parameter: (n * 2^30) / d, saturated.
// One quotient bit per stage, COORD_WIDTH + 2 stages in all; uses rbst_pkg.
`default_nettype none

module rbst_div #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [COORD_WIDTH:0]          num_mag,
    input  wire logic [rbst_pkg::DIR_W-1:0]    den_mag,
    input  wire logic                          neg,
    output logic signed [COORD_WIDTH-1:0]      result
);
    import rbst_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int NN_W   = CW + 1 + DIR_FRAC;
    localparam int WIDE_W = CW + DIR_W;

    logic [DIR_W-1:0] rem_reg [CW+1];
    logic [CW-1:0]    low_reg [CW+1];
    logic [CW-1:0]    q_reg   [CW+1];
    logic             ovf_reg [CW+1];
    logic             neg_reg [CW+1];
    logic signed [CW-1:0] result_reg;

    logic [NN_W-1:0]   n_shift;
    logic [WIDE_W-1:0] n_wide, d_wide;
    logic [DIR_W:0]    trial [CW];
    logic              ge    [CW];
    logic              sat;

    always_comb begin
        n_shift = {num_mag, {DIR_FRAC{1'b0}}};
        n_wide  = WIDE_W'(n_shift);
        d_wide  = {den_mag, {CW{1'b0}}};
        for (int j = 0; j < CW; j++) begin
            trial[j] = {rem_reg[j], low_reg[j][CW-1]};
            ge[j]    = trial[j] >= {1'b0, den_mag};
        end
        sat = ovf_reg[CW] | q_reg[CW][CW-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // quotient of CW bits suffices unless it reaches 2^CW
            ovf_reg[0] <= n_wide >= d_wide;
            rem_reg[0] <= DIR_W'(n_shift[NN_W-1:CW]);
            low_reg[0] <= n_shift[CW-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            for (int j = 0; j < CW; j++) begin
                rem_reg[j+1] <= ge[j] ? DIR_W'(trial[j] - {1'b0, den_mag})
                                      : DIR_W'(trial[j]);
                low_reg[j+1] <= low_reg[j] << 1;
                q_reg[j+1]   <= {q_reg[j][CW-2:0], ge[j]};
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            if (neg_reg[CW]) begin
                result_reg <= sat ? {1'b1, {(CW-1){1'b0}}} : (~q_reg[CW] + 1'b1);
            end else begin
                result_reg <= sat ? {1'b0, {(CW-1){1'b1}}} : q_reg[CW];
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[hw/rtl/rbst_reduce.sv]
// Slab interval reduction: order each axis pair, then entry max against exit min.
// Three register stages, the last one being the result register; uses rbst_pkg.
`default_nettype none

module rbst_reduce #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [COORD_WIDTH-1:0] t_a [3],
    input  wire logic signed [COORD_WIDTH-1:0] t_b [3],
    input  wire logic [2:0]                    nz,
    input  wire logic                          zmiss,
    input  wire logic signed [COORD_WIDTH-1:0] tfar0,
    output logic                               hit
);
    import rbst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] CMAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] CZERO = {CW{1'b0}};

    logic signed [CW-1:0] lo_reg [3];
    logic signed [CW-1:0] hi_reg [3];
    logic signed [CW-1:0] tfar0_reg, tnear_reg, tfar_reg;
    logic                 zmiss1_reg, zmiss2_reg, hit_reg;

    logic signed [CW-1:0] lo_next [3];
    logic signed [CW-1:0] hi_next [3];
    logic signed [CW-1:0] n01, n23, f01, f23, tnear_next, tfar_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!nz[k]) begin
                lo_next[k] = CMIN;
                hi_next[k] = CMAX;
            end else if (t_a[k] > t_b[k]) begin
                lo_next[k] = t_b[k];
                hi_next[k] = t_a[k];
            end else begin
                lo_next[k] = t_a[k];
                hi_next[k] = t_b[k];
            end
        end
        // entry parameter never drops below zero
        n01 = (lo_reg[0] > CZERO) ? lo_reg[0] : CZERO;
        n23 = (lo_reg[1] > lo_reg[2]) ? lo_reg[1] : lo_reg[2];
        tnear_next = (n23 > n01) ? n23 : n01;
        f01 = (hi_reg[0] < tfar0_reg) ? hi_reg[0] : tfar0_reg;
        f23 = (hi_reg[1] < hi_reg[2]) ? hi_reg[1] : hi_reg[2];
        tfar_next = (f23 < f01) ? f23 : f01;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            tfar0_reg  <= tfar0;
            zmiss1_reg <= zmiss;
            tnear_reg  <= tnear_next;
            tfar_reg   <= tfar_next;
            zmiss2_reg <= zmiss1_reg;
            hit_reg    <= !zmiss2_reg && (tnear_reg <= tfar_reg);
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

[hw/rtl/ray_box_slab_test.sv]
// Ray versus padded axis-aligned box slab test, signed fixed point, top level.
// Fully pipelined from input beat to result beat; most of its stages lie in the per-lane
// divider, which resolves one quotient bit per stage.
// Throughput one box per cycle; a stalled result beat freezes the whole pipeline.
// Reset (aresetn low, synchronous) empties the pipeline and restores the ray registers.
// Uses rbst_pkg, rbst_margin, rbst_div and rbst_reduce.
`default_nettype none

module ray_box_slab_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int CFG_W      = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
    localparam int S_DATA_W   = ((7 * COORD_WIDTH - 1 + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rbst_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_W-1:0]                cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, search_limit
    input  wire logic [S_DATA_W-1:0]             s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // box_hit
    output logic [7:0]                           m_tdata
);
    import rbst_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int NUM_W   = CW + 2;
    localparam int DIV_LAT = CW + 2;
    localparam int LAT     = CW + 12;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct packed {
        logic [2:0]           nz;
        logic                 zmiss;
        logic signed [CW-1:0] tfar0;
    } side_t;

    // configuration
    logic signed [CW-1:0]    org_reg [3];
    logic signed [DIR_W-1:0] dir_reg [3];
    logic [SCALE_W-1:0]      scale_reg;

    logic [LAT-1:0] v_reg;
    logic           en;

    logic signed [CW-1:0] lo1_reg [3];
    logic signed [CW-1:0] hi1_reg [3];
    logic [CW-2:0]        lim1_reg;
    logic signed [CW-1:0] lo_d_reg [4][3];
    logic signed [CW-1:0] hi_d_reg [4][3];

    logic [CW-1:0] margin;
    logic [CW-2:0] lim5;

    logic signed [NUM_W-1:0] a_num_reg [3];
    logic signed [NUM_W-1:0] b_num_reg [3];
    logic signed [CW-1:0]    tfar0_reg;

    logic [CW:0] a_mag_reg [3];
    logic [CW:0] b_mag_reg [3];
    logic [2:0]  a_neg_reg, b_neg_reg;
    side_t       side7_reg;
    side_t       side_d_reg [DIV_LAT];

    logic signed [CW-1:0] t_a [3];
    logic signed [CW-1:0] t_b [3];
    logic [DIR_W-1:0]     den_mag [3];
    logic                 hit;

    logic signed [NUM_W-1:0] a_num_next [3];
    logic signed [NUM_W-1:0] b_num_next [3];
    logic [CW:0]             tsum;
    logic [2:0]              nz_w, zm_w;

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;
    assign m_tvalid = v_reg[LAT-1];
    assign m_tdata  = {7'b0, hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg   <= '{default: '0};
            dir_reg   <= '{DIR_X_RESET, '0, '0};
            scale_reg <= MARGIN_SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_ORIGIN_X:     org_reg[0] <= cfg_wr_data[CW-1:0];
                REG_ORIGIN_Y:     org_reg[1] <= cfg_wr_data[CW-1:0];
                REG_ORIGIN_Z:     org_reg[2] <= cfg_wr_data[CW-1:0];
                REG_DIR_X:        dir_reg[0] <= cfg_wr_data[DIR_W-1:0];
                REG_DIR_Y:        dir_reg[1] <= cfg_wr_data[DIR_W-1:0];
                REG_DIR_Z:        dir_reg[2] <= cfg_wr_data[DIR_W-1:0];
                REG_MARGIN_SCALE: scale_reg  <= cfg_wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAT-2:0], s_tvalid};
        end
    end

    rbst_margin #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_margin (
        .aclk         (aclk),
        .en           (en),
        .origin_x     (org_reg[0]),
        .origin_y     (org_reg[1]),
        .origin_z     (org_reg[2]),
        .margin_scale (scale_reg),
        .limit_in     (lim1_reg),
        .margin       (margin),
        .limit_out    (lim5)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_num_next[k] = NUM_W'(lo_d_reg[3][k]) - $signed({2'b0, margin})
                            - NUM_W'(org_reg[k]);
            b_num_next[k] = NUM_W'(hi_d_reg[3][k]) + $signed({2'b0, margin})
                            - NUM_W'(org_reg[k]);
            den_mag[k] = dir_reg[k][DIR_W-1] ? DIR_W'(-dir_reg[k]) : DIR_W'(dir_reg[k]);
            nz_w[k]    = dir_reg[k] != '0;
            // zero direction: origin must lie inside the padded slab
            zm_w[k]    = !nz_w[k] && ((!a_num_reg[k][NUM_W-1] && a_num_reg[k] != '0)
                                      || b_num_reg[k][NUM_W-1]);
        end
        tsum = (CW+1)'(lim5) + (CW+1)'(margin);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                lo1_reg[k] <= s_tdata[k*CW +: CW];
                hi1_reg[k] <= s_tdata[(k+3)*CW +: CW];
            end
            lim1_reg <= s_tdata[6*CW +: CW-1];
            lo_d_reg[0] <= lo1_reg;
            hi_d_reg[0] <= hi1_reg;
            for (int i = 1; i < 4; i++) begin
                lo_d_reg[i] <= lo_d_reg[i-1];
                hi_d_reg[i] <= hi_d_reg[i-1];
            end
            a_num_reg <= a_num_next;
            b_num_reg <= b_num_next;
            tfar0_reg <= (tsum > (CW+1)'(CMAX)) ? CMAX : CW'(tsum);
            for (int k = 0; k < 3; k++) begin
                a_mag_reg[k] <= a_num_reg[k][NUM_W-1] ? (CW+1)'(-a_num_reg[k])
                                                      : (CW+1)'(a_num_reg[k]);
                b_mag_reg[k] <= b_num_reg[k][NUM_W-1] ? (CW+1)'(-b_num_reg[k])
                                                      : (CW+1)'(b_num_reg[k]);
                a_neg_reg[k] <= a_num_reg[k][NUM_W-1] ^ dir_reg[k][DIR_W-1];
                b_neg_reg[k] <= b_num_reg[k][NUM_W-1] ^ dir_reg[k][DIR_W-1];
            end
            side7_reg.nz    <= nz_w;
            side7_reg.zmiss <= |zm_w;
            side7_reg.tfar0 <= tfar0_reg;
            side_d_reg[0]   <= side7_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_d_reg[i] <= side_d_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        rbst_div #(.COORD_WIDTH(CW)) u_div_a (
            .aclk    (aclk),
            .en      (en),
            .num_mag (a_mag_reg[k]),
            .den_mag (den_mag[k]),
            .neg     (a_neg_reg[k]),
            .result  (t_a[k])
        );
        rbst_div #(.COORD_WIDTH(CW)) u_div_b (
            .aclk    (aclk),
            .en      (en),
            .num_mag (b_mag_reg[k]),
            .den_mag (den_mag[k]),
            .neg     (b_neg_reg[k]),
            .result  (t_b[k])
        );
    end

    rbst_reduce #(.COORD_WIDTH(CW)) u_reduce (
        .aclk  (aclk),
        .en    (en),
        .t_a   (t_a),
        .t_b   (t_b),
        .nz    (side_d_reg[DIV_LAT-1].nz),
        .zmiss (side_d_reg[DIV_LAT-1].zmiss),
        .tfar0 (side_d_reg[DIV_LAT-1].tfar0),
        .hit   (hit)
    );

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("valid bits moved during a stall");

    a_last_stage_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[LAT-2] && en) |=> m_tvalid)
        else $error("result beat lost on its way to the output register");

    a_exit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[5] |-> !tfar0_reg[CW-1])
        else $error("exit start parameter went negative");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input held off without a stalled result");

endmodule

`default_nettype wire

[tb/ray_box_slab_test_tb.sv]
// Self-checking testbench for ray_box_slab_test: it drives box beats, predicts each hit bit
// and checks the result beats. It depends on rbst_pkg and the ray_box_slab_test top level.
`timescale 1ns / 1ps

module ray_box_slab_test_tb;
    import rbst_pkg::*;

    localparam int  S_W       = 224;
    localparam int  LATENCY   = 44;
    localparam int  MAX_CYCLES = 400000;

    logic           aclk;
    logic           aresetn;
    logic           cfg_wr_en;
    logic [2:0]     cfg_wr_index;
    logic [31:0]    cfg_wr_data;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [7:0]     m_tdata;

    ray_box_slab_test u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Ray set-up copy, hit predictor and store of expected hit bits.
    class slab_scoreboard;
        longint          org [3];
        longint          dir [3];
        longint unsigned scale;
        bit              hit_q [$];
        int              errors;
        int              boxes;
        int              hits;

        function new();
            org[0] = 0; org[1] = 0; org[2] = 0;
            dir[0] = longint'(DIR_X_RESET); dir[1] = 0; dir[2] = 0;
            scale = longint'(MARGIN_SCALE_RESET);
        endfunction

        function void write_reg(cfg_reg_t r, logic [31:0] d);
            case (r)
                REG_ORIGIN_X: org[0] = longint'(signed'(d));
                REG_ORIGIN_Y: org[1] = longint'(signed'(d));
                REG_ORIGIN_Z: org[2] = longint'(signed'(d));
                REG_DIR_X: dir[0] = longint'(signed'(d));
                REG_DIR_Y: dir[1] = longint'(signed'(d));
                REG_DIR_Z: dir[2] = longint'(signed'(d));
                REG_MARGIN_SCALE: scale = {32'd0, d};
                default: ;
            endcase
        endfunction

        static function longint unsigned mag_of(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // (num * 2^30) / den, magnitude truncated, saturated to the Q16.16 range
        static function longint slab_param(longint num, longint den);
            longint unsigned cap, n, d, q, r, m;
            longint v;
            cap = 64'd1 << 31;
            n = mag_of(num);
            d = mag_of(den);
            q = n / d;
            r = n % d;
            if (q > (cap >> DIR_FRAC)) begin
                m = cap;
            end else begin
                m = (q << DIR_FRAC) + ((r << DIR_FRAC) / d);
                if (m > cap) m = cap;
            end
            v = longint'(m);
            if ((num < 0) != (den < 0)) v = -v;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v;
        endfunction

        function bit predict_hit(logic [S_W-1:0] d);
            longint lo [3];
            longint hi [3];
            longint limit, margin, tnear, tfar, a, b, t;
            longint unsigned mag;
            bit hit;
            for (int k = 0; k < 3; k++) begin
                lo[k] = longint'(signed'(d[32*k +: 32]));
                hi[k] = longint'(signed'(d[32*(k+3) +: 32]));
            end
            limit = {33'd0, d[222:192]};
            mag = 64'd1 << 16;
            for (int k = 0; k < 3; k++)
                if (mag_of(org[k]) > mag) mag = mag_of(org[k]);
            if (longint'(limit) > longint'(mag)) mag = limit;
            margin = (scale * (mag >> 16) + ((scale * (mag & 64'hFFFF)) >> 16)) >> 16;
            tnear = 0;
            tfar = limit + margin;
            if (tfar > 64'sd2147483647) tfar = 64'sd2147483647;
            hit = 1;
            for (int k = 0; k < 3 && hit; k++) begin
                if (dir[k] == 0) begin
                    if (org[k] < lo[k] - margin || org[k] > hi[k] + margin) hit = 0;
                end else begin
                    a = slab_param(lo[k] - margin - org[k], dir[k]);
                    b = slab_param(hi[k] + margin - org[k], dir[k]);
                    if (a > b) begin
                        t = a; a = b; b = t;
                    end
                    if (a > tnear) tnear = a;
                    if (b < tfar) tfar = b;
                    if (tnear > tfar) hit = 0;
                end
            end
            return hit;
        endfunction

        function void note_box(logic [S_W-1:0] d);
            bit h;
            h = predict_hit(d);
            hit_q = {hit_q, h};
            boxes++;
            hits += h;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_hit(bit got);
            bit want;
            if (hit_q.size() == 0) begin
                report($sformatf("result beat box_hit=%0d with nothing expected", got));
            end else begin
                want = hit_q.pop_front();
                if (got !== want)
                    report($sformatf("box_hit got %0d expected %0d", got, want));
            end
        endtask
    endclass

    slab_scoreboard sb = new();
    bit  send_quiet;
    bit  recv_quiet;
    bit  hold_req;
    int  cycles;

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Monitors: note accepted boxes, check accepted results.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_box(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_hit(m_tdata[0]);
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int st;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
                st = recv_quiet ? 0 : $urandom_range(0, 5);
                if (st > 0) begin
                    m_tready <= 1'b0;
                    repeat (st) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task write_reg(cfg_reg_t r, logic [31:0] d);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= r;
        cfg_wr_data  <= d;
        sb.write_reg(r, d);
        @(posedge aclk);
    endtask

    task write_ray(longint ox, longint oy, longint oz, longint dx, longint dy, longint dz,
                   longint unsigned ms);
        write_reg(REG_ORIGIN_X, ox[31:0]);
        write_reg(REG_ORIGIN_Y, oy[31:0]);
        write_reg(REG_ORIGIN_Z, oz[31:0]);
        write_reg(REG_DIR_X, dx[31:0]);
        write_reg(REG_DIR_Y, dy[31:0]);
        write_reg(REG_DIR_Z, dz[31:0]);
        write_reg(REG_MARGIN_SCALE, ms[31:0]);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task send_box(longint mnx, longint mny, longint mnz, longint mxx, longint mxy,
                  longint mxz, longint lim);
        int gap;
        if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, lim[30:0], mxz[31:0], mxy[31:0], mxx[31:0],
                     mnz[31:0], mny[31:0], mnx[31:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drain: hold until every hit bit is back, then let the pipeline settle.
    task drain();
        s_tvalid <= 1'b0;
        while (sb.hit_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    function automatic longint rnd_dir();
        if ($urandom_range(0, 3) == 0) return 0;
        return longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
    endfunction

    function automatic longint rnd_org();
        if ($urandom_range(0, 3) == 0) return longint'(signed'($urandom));
        return longint'($urandom_range(0, 32'h0020_0000)) - 64'sd1048576;
    endfunction

    // Mostly boxes placed on the ray with random size and limit, the rest pure noise.
    task random_boxes(int n);
        longint t, half, lim;
        longint p [3];
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                t = $urandom_range(0, 32'h0040_0000);
                for (int k = 0; k < 3; k++)
                    p[k] = sb.org[k] + ((sb.dir[k] * t) >>> 30);
                half = $urandom_range(0, 32'h0004_0000);
                lim  = (t > 64'sd65536) ? t - 65536 : 0;
                lim  = lim + $urandom_range(0, 32'h0008_0000);
                send_box(p[0] - half - $urandom_range(0, 4096), p[1] - half,
                         p[2] - half - $urandom_range(0, 4096), p[0] + half,
                         p[1] + half + $urandom_range(0, 4096), p[2] + half, lim);
            end else begin
                send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         {32'd0, $urandom} & 64'h7FFF_FFFF);
            end
        end
    endtask

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;
    localparam longint DONE = 64'sd1073741824;

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        send_quiet   = 1'b0;
        recv_quiet   = 1'b0;
        hold_req     = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset ray: +x from the origin, default margin.
        send_box(ONE, -ONE, -ONE, 2*ONE, ONE, ONE, 10*ONE);
        send_box(-3*ONE, -ONE, -ONE, -2*ONE, ONE, ONE, 10*ONE);
        send_box(20*ONE, -ONE, -ONE, 21*ONE, ONE, ONE, 10*ONE);
        send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0);
        send_box(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX);
        send_box(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMAX);
        send_box(ONE, 2*ONE, -ONE, 2*ONE, 3*ONE, ONE, 10*ONE);
        send_box(ONE, 0, 0, 2*ONE, 0, 0, 10*ONE);
        send_box(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0);
        send_box(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMAX);
        drain();

        // Extreme ray: far corner, reversed direction, widest margin.
        write_ray(QMAX, QMIN, QMAX, -DONE, 0, DONE, 64'hFFFF_FFFF);
        send_box(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX);
        send_box(0, QMIN, 0, ONE, QMIN, ONE, QMAX);
        send_box(QMIN, QMAX, QMIN, QMIN, QMAX, QMIN, 0);
        send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 5*ONE);
        drain();

        // Tiny oblique direction saturates the slab parameters; no margin; then random boxes.
        write_ray(QMIN, 0, QMIN, 1, -1, 1, 0);
        send_box(QMIN, -ONE, QMIN, QMAX, ONE, QMAX, QMAX);
        send_box(0, 0, 0, ONE, ONE, ONE, QMAX);
        send_box(QMIN, 0, QMIN, QMIN, 0, QMIN, 0);
        random_boxes(100);
        drain();

        // Random rays; fill the pipeline under a long result stall in one phase.
        for (int ph = 0; ph < 7; ph++) begin
            write_ray(rnd_org(), rnd_org(), rnd_org(), rnd_dir(), rnd_dir(), rnd_dir(),
                      ($urandom_range(0, 1) != 0) ? {32'd0, $urandom}
                                                  : $urandom_range(0, 65536));
            if (ph == 1) hold_req = 1'b1;
            random_boxes(235);
            drain();
        end

        $display("%0d boxes over 10 ray set-ups, %0d predicted hits, %0d misses",
                 sb.boxes, sb.hits, sb.boxes - sb.hits);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_margin.sv
hw/rtl/rbst_div.sv
hw/rtl/rbst_reduce.sv
hw/rtl/ray_box_slab_test.sv
tb/ray_box_slab_test_tb.sv
